// ----- hw/rtl/srgblab_pkg.sv -----
// Shared constants, types and the sRGB linearization table for the sRGB to CIELAB unit.
// No dependencies; every other file of the block refers to this package by scoped names.
`default_nettype none

package srgblab_pkg;

  localparam int QBITS = 30;             // fraction bits of every internal quantity
  localparam int LIN_W = 31;             // linear channel and f() result width
  localparam int QUO_W = 31;             // quotient bits of the constant dividers
  localparam int DIV_LAT = 3;            // latency of one constant divider
  localparam int PROD_W = 55;            // linear channel times matrix coefficient
  localparam int SUM_W = 56;             // matrix row sum plus rounding term
  localparam int F_NUM_W = 45;           // numerator of the linear f() segment
  localparam int F_LAT = 2 * QUO_W + 2;  // latency of one f() unit
  localparam int ACC_W = 42;             // L, a and b before output rounding
  localparam int DEF_OUT_FRAC_BITS = 8;

  // sRGB to XYZ matrix in units of 1e-7, row major (X, Y, Z rows).
  localparam logic [23:0] MAT [9] = '{
    24'd4124564, 24'd3575761, 24'd1804375,
    24'd2126729, 24'd7151522, 24'd721750,
    24'd193339,  24'd1191920, 24'd9503041
  };

  // White point times 1e7 and half of it for round-half-up.
  localparam int WHITE_DIV [3] = '{9504560, 10000000, 10887540};
  localparam logic [23:0] WHITE_RND [3] = '{24'd4752280, 24'd5000000, 24'd5443770};

  // Linear f() segment: (9033*t + 160*2^30 + 580) / 1160.
  localparam logic [13:0] F_SLOPE = 14'd9033;
  localparam logic [F_NUM_W-1:0] F_OFFSET = F_NUM_W'((64'd160 << QBITS) + 64'd580);
  localparam int F_DIV = 1160;
  // t*10^6 > 8856*2^30 is the same as t > floor(8856*2^30 / 10^6).
  localparam logic [LIN_W-1:0] F_CUBE_THR = LIN_W'((64'd8856 << QBITS) / 64'd1000000);

  typedef logic [LIN_W-1:0] lin_tab_t [256];

  function automatic longint unsigned qmul(input longint unsigned a, input longint unsigned b);
    return (a * b) >> QBITS;
  endfunction

  // Largest y in [0, 2^30] whose Q30 fifth power does not exceed t.
  function automatic longint unsigned qroot5(input longint unsigned t);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned p;
    lo = 0;
    hi = longint'(1) << QBITS;
    while (lo < hi) begin
      mid = lo + ((hi - lo + 1) >> 1);
      p = qmul(qmul(qmul(qmul(mid, mid), mid), mid), mid);
      if (p <= t) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    return lo;
  endfunction

  function automatic longint unsigned lin_value(input int v);
    longint unsigned vv;
    longint unsigned s;
    longint unsigned q;
    vv = longint'(v);
    if (vv * 100000 <= 1031475) begin
      return (((vv * 10) << QBITS) + 16473) / 32946;
    end
    s = ((((1000 * vv) + 14025) << QBITS) + 134512) / 269025;
    q = qmul(s, s);
    return qmul(q, qroot5(q));
  endfunction

  function automatic lin_tab_t build_lin_table();
    lin_tab_t tab;
    for (int i = 0; i < 256; i++) begin
      tab[i] = LIN_W'(lin_value(i));
    end
    return tab;
  endfunction

  localparam lin_tab_t LIN_TABLE = build_lin_table();

endpackage

`default_nettype wire

// ----- hw/rtl/srgblab_cdiv.sv -----
// Pipelined divider by a constant: reciprocal product, back product and a small correction.
// Uses srgblab_pkg for the quotient width; the dividend must stay below DIVISOR * 2^QUO_W.
`default_nettype none

module srgblab_cdiv #(
  parameter int DIVISOR = 1160,
  parameter int NUM_W = 45
) (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic [NUM_W-1:0]              num_i,
  output logic      [srgblab_pkg::QUO_W-1:0] quo_o
);

  localparam int QW = srgblab_pkg::QUO_W;
  localparam int RW = $clog2(DIVISOR);
  localparam int TW = 32;
  localparam int MW = TW + 1;
  localparam int EW = RW + 2;
  localparam logic [MW-1:0] Recip = MW'((64'd1 << (RW + TW)) / 64'(DIVISOR));
  localparam logic [EW-1:0] Div1 = EW'(DIVISOR);
  localparam logic [EW-1:0] Div2 = EW'(2 * DIVISOR);
  localparam logic [EW-1:0] Div3 = EW'(3 * DIVISOR);

  logic [QW+MW-1:0] est_q;
  logic [EW-1:0]    nlo1_q;
  logic [EW-1:0]    nlo2_q;
  logic [QW-1:0]    q0_q;
  logic [EW-1:0]    back_q;
  logic [QW-1:0]    quo_q;
  logic [EW-1:0]    rem;
  logic [1:0]       adj;

  // The estimate from the upper dividend bits is low by at most three, so the
  // remainder stays below 4 * DIVISOR and only its low bits are carried.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      est_q  <= (QW+MW)'(num_i[QW+RW-1:RW]) * (QW+MW)'(Recip);
      nlo1_q <= num_i[EW-1:0];
      q0_q   <= est_q[TW+QW-1:TW];
      back_q <= est_q[TW+EW-1:TW] * Div1;
      nlo2_q <= nlo1_q;
      quo_q  <= q0_q + QW'(adj);
    end
  end

  assign rem = nlo2_q - back_q;

  always_comb begin
    priority if (rem >= Div3) begin
      adj = 2'd3;
    end else if (rem >= Div2) begin
      adj = 2'd2;
    end else if (rem >= Div1) begin
      adj = 2'd1;
    end else begin
      adj = 2'd0;
    end
  end

  assign quo_o = quo_q;

endmodule

`default_nettype wire

// ----- hw/rtl/srgblab_cbrt_f.sv -----
// CIE f() unit: pipelined bit-by-bit cube root beside a constant divider for the linear segment.
// Depends on srgblab_pkg and srgblab_cdiv.
`default_nettype none

module srgblab_cbrt_f (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic [srgblab_pkg::LIN_W-1:0] t_i,
  output logic      [srgblab_pkg::LIN_W-1:0] f_o
);

  localparam int QW = srgblab_pkg::QUO_W;
  localparam int LW = srgblab_pkg::LIN_W;
  localparam int NW = srgblab_pkg::F_NUM_W;
  localparam int QB = srgblab_pkg::QBITS;
  localparam int RootLat = 2 * QW;
  localparam int LinDly = RootLat - srgblab_pkg::DIV_LAT;

  logic [LW-1:0] t_p_q;
  logic          cube_p_q;
  logic [NW-1:0] num_p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_p_q    <= t_i;
      cube_p_q <= (t_i > srgblab_pkg::F_CUBE_THR);
      num_p_q  <= NW'(t_i) * NW'(srgblab_pkg::F_SLOPE) + srgblab_pkg::F_OFFSET;
    end
  end

  // Linear segment, delayed to line up with the root result.
  logic [QW-1:0] quo;
  logic [QW-1:0] qd_q [LinDly];

  srgblab_cdiv #(
    .DIVISOR(srgblab_pkg::F_DIV),
    .NUM_W  (NW)
  ) u_lin_div (
    .clk_i(clk_i),
    .en_i (en_i),
    .num_i(num_p_q),
    .quo_o(quo)
  );

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qd_q[0] <= quo;
      for (int i = 1; i < LinDly; i++) begin
        qd_q[i] <= qd_q[i-1];
      end
    end
  end

  logic cube_d_q [RootLat];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cube_d_q[0] <= cube_p_q;
      for (int i = 1; i < RootLat; i++) begin
        cube_d_q[i] <= cube_d_q[i-1];
      end
    end
  end

  // Cube root: each bit takes a square stage and a cube-and-compare stage.
  logic [LW-1:0] ca_q [QW];
  logic [LW:0]   sqa_q [QW];
  logic [LW-1:0] ya_q [QW];
  logic [LW-1:0] ta_q [QW];
  logic [LW-1:0] yb_q [QW];
  logic [LW-1:0] tb_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_bit
    localparam logic [LW-1:0] Bit = LW'(1) << (LW - 1 - k);
    logic [LW-1:0]     yin;
    logic [LW-1:0]     tin;
    logic [LW-1:0]     cand;
    logic [2*LW-1:0]   sq_prod;
    logic [2*LW:0]     cube_prod;
    logic [2*LW-QB:0]  cube;

    if (k == 0) begin : g_first
      assign yin = '0;
      assign tin = t_p_q;
    end else begin : g_next
      assign yin = yb_q[k-1];
      assign tin = tb_q[k-1];
    end

    assign cand      = yin | Bit;
    assign sq_prod   = (2*LW)'(cand) * (2*LW)'(cand);
    assign cube_prod = (2*LW+1)'(sqa_q[k]) * (2*LW+1)'(ca_q[k]);
    assign cube      = cube_prod[2*LW:QB];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ca_q[k]  <= cand;
        sqa_q[k] <= sq_prod[2*LW-1:QB];
        ya_q[k]  <= yin;
        ta_q[k]  <= tin;
        yb_q[k]  <= (cube <= (2*LW-QB+1)'(ta_q[k])) ? ca_q[k] : ya_q[k];
        tb_q[k]  <= ta_q[k];
      end
    end
  end

  logic [LW-1:0] f_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_q <= cube_d_q[RootLat-1] ? yb_q[QW-1] : qd_q[LinDly-1];
    end
  end

  assign f_o = f_q;

endmodule

`default_nettype wire

// ----- hw/rtl/srgb_to_cielab_unit.sv -----
// sRGB to CIELAB (D65) pixel converter, top level.
// Depends on srgblab_pkg, srgblab_cdiv and srgblab_cbrt_f.
//
// Input channel: in_valid_i with red_i, green_i, blue_i and last_pixel_i; a beat is
// taken when in_valid_i is high and in_stall_o is low. Output channel: out_valid_o
// with lightness_o, green_red_o, blue_yellow_o and last_out_o; a beat leaves when
// out_valid_o is high and out_stall_i is low. L, a and b carry OUT_FRAC_BITS
// fraction bits, rounded to nearest, L clamped to 0..100 and a, b to 16 bits.
//
// One pixel enters per clock unless stalled. Stages: table lookup, matrix products,
// row sums, three divider stages for the white point (reciprocal product, back
// product, correction), 64 stages of the f() unit (input register, two per cube
// root bit, output register) and two output stages. The pipeline moves as a whole:
// while an output beat waits under out_stall_i, every stage holds and in_stall_o is
// raised, so nothing is lost or repeated. Reset clears the valid bits only; no
// pixel is lost on idle cycles, and the first beat may be sent right after reset.
`default_nettype none

module srgb_to_cielab_unit #(
  parameter int OUT_FRAC_BITS = srgblab_pkg::DEF_OUT_FRAC_BITS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  red_i,
  input  wire logic [7:0]  green_i,
  input  wire logic [7:0]  blue_i,
  input  wire logic        last_pixel_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [14:0]      lightness_o,
  output logic [15:0]      green_red_o,
  output logic [15:0]      blue_yellow_o,
  output logic             last_out_o
);

  localparam int LW = srgblab_pkg::LIN_W;
  localparam int PW = srgblab_pkg::PROD_W;
  localparam int SW = srgblab_pkg::SUM_W;
  localparam int AW = srgblab_pkg::ACC_W;
  localparam int QB = srgblab_pkg::QBITS;
  localparam int Lat = 3 + srgblab_pkg::DIV_LAT + srgblab_pkg::F_LAT + 2;
  localparam int Sh = QB - OUT_FRAC_BITS;
  localparam logic signed [AW-1:0] Half = AW'(1) <<< (Sh - 1);
  localparam longint LMaxFull = longint'(100) << OUT_FRAC_BITS;
  localparam logic signed [AW-1:0] LMax = AW'((LMaxFull > 32767) ? 32767 : LMaxFull);

  logic en;
  logic vld_q [Lat];
  logic last_q [Lat];

  assign en         = !(vld_q[Lat-1] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Lat; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i < Lat; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      last_q[0] <= last_pixel_i;
      for (int i = 1; i < Lat; i++) begin
        last_q[i] <= last_q[i-1];
      end
    end
  end

  // Linearization, matrix products and row sums with the white point rounding term.
  logic [LW-1:0] lin_q [3];
  logic [PW-1:0] prod_q [9];
  logic [SW-1:0] sum_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      lin_q[0] <= srgblab_pkg::LIN_TABLE[red_i];
      lin_q[1] <= srgblab_pkg::LIN_TABLE[green_i];
      lin_q[2] <= srgblab_pkg::LIN_TABLE[blue_i];
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          prod_q[j*3+i] <= PW'(lin_q[i]) * PW'(srgblab_pkg::MAT[j*3+i]);
        end
      end
      for (int j = 0; j < 3; j++) begin
        sum_q[j] <= SW'(prod_q[j*3]) + SW'(prod_q[j*3+1]) + SW'(prod_q[j*3+2])
                  + SW'(srgblab_pkg::WHITE_RND[j]);
      end
    end
  end

  logic [LW-1:0] rel [3];
  logic [LW-1:0] fval [3];

  for (genvar c = 0; c < 3; c++) begin : g_chan
    srgblab_cdiv #(
      .DIVISOR(srgblab_pkg::WHITE_DIV[c]),
      .NUM_W  (SW)
    ) u_white_div (
      .clk_i(clk_i),
      .en_i (en),
      .num_i(sum_q[c]),
      .quo_o(rel[c])
    );

    srgblab_cbrt_f u_f (
      .clk_i(clk_i),
      .en_i (en),
      .t_i  (rel[c]),
      .f_o  (fval[c])
    );
  end

  function automatic logic signed [AW-1:0] round_out(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] mag;
    logic signed [AW-1:0] m;
    mag = v[AW-1] ? -v : v;
    m = (mag + Half) >>> Sh;
    return v[AW-1] ? -m : m;
  endfunction

  function automatic logic [15:0] sat16(input logic signed [AW-1:0] v);
    if (v < -AW'(32768)) begin
      return 16'h8000;
    end
    if (v > AW'(32767)) begin
      return 16'h7fff;
    end
    return v[15:0];
  endfunction

  logic signed [AW-1:0] fx;
  logic signed [AW-1:0] fy;
  logic signed [AW-1:0] fz;
  logic signed [AW-1:0] lq_q;
  logic signed [AW-1:0] aq_q;
  logic signed [AW-1:0] bq_q;
  logic signed [AW-1:0] lr;
  logic [14:0]          light_q;
  logic [15:0]          gr_q;
  logic [15:0]          by_q;

  assign fx = $signed(AW'(fval[0]));
  assign fy = $signed(AW'(fval[1]));
  assign fz = $signed(AW'(fval[2]));
  assign lr = round_out(lq_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      lq_q <= fy * AW'(116) - (AW'(16) <<< QB);
      aq_q <= (fx - fy) * AW'(500);
      bq_q <= (fy - fz) * AW'(200);
      if (lr[AW-1]) begin
        light_q <= '0;
      end else if (lr > LMax) begin
        light_q <= LMax[14:0];
      end else begin
        light_q <= lr[14:0];
      end
      gr_q <= sat16(round_out(aq_q));
      by_q <= sat16(round_out(bq_q));
    end
  end

  assign out_valid_o   = vld_q[Lat-1];
  assign last_out_o    = last_q[Lat-1];
  assign lightness_o   = light_q;
  assign green_red_o   = gr_q;
  assign blue_yellow_o = by_q;

endmodule

`default_nettype wire
